// ----- rtl/core/omni_wheel_drive_mixer_defines.svh -----
// Assertion macros for the omni wheel drive mixer checker.
// Depends on nothing; the asserting scope supplies clk_i and rst_ni.
`ifndef OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH
`define OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OWDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OWDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/owdm_pkg.sv -----
// Shared types and constants of the omni wheel drive mixer.
// Used by every design module of the block; depends on nothing.
package owdm_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned OsW       = 8;
  localparam int unsigned TrimW     = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned NumW      = 50;
  localparam int unsigned DenW      = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegOpSpeed = 3'd0,
    RegTrimFl  = 3'd1,
    RegTrimFr  = 3'd2,
    RegTrimRl  = 3'd3,
    RegTrimRr  = 3'd4
  } cfg_reg_e;

  localparam logic [OsW-1:0]   OsReset   = 8'd255;
  localparam logic [TrimW-1:0] TrimReset = 10'd256;

  // Square of the translate divisor and the saturation threshold on r^2 * os^2.
  localparam logic [31:0] XlateDivSq = 32'd1310720000;
  localparam logic [31:0] XlateSatSq = 32'd1300500000;

  // Rotate: 255 * 100 caps the speed product; 256 * 25600 clamps the PWM.
  localparam logic [14:0] RotCap       = 15'd25500;
  localparam logic [24:0] RotClampLim  = 25'd6553600;
  localparam logic [15:0] RecipHundred = 16'd41944;

  typedef struct packed {
    logic [OsW-1:0]                  speed;
    logic [NumWheels-1:0][TrimW-1:0] trim;
  } cfg_t;

  typedef struct packed {
    logic                           rot;
    logic [NumWheels-1:0]           neg;
    logic [NumWheels-1:0][7:0]      pwm_rot;
    logic [NumWheels-1:0][NumW-1:0] num;
    logic [DenW-1:0]                den;
    logic [NumWheels-1:0][7:0]      root;
    logic [NumWheels-1:0][15:0]     sq;
  } work_t;

endpackage

// ----- rtl/core/owdm_front.sv -----
// Front end of the mixer: three stages that form each wheel's radicand, the shared divisor
// and the finished rotate magnitudes. Depends on owdm_pkg.
module owdm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic                 op_i,
  input  logic signed [7:0]    stick_x_i,
  input  logic signed [7:0]    stick_y_i,
  input  logic signed [7:0]    turn_percent_i,
  input  owdm_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output owdm_pkg::work_t      work_o
);

  // Stage 1
  logic        s1_v_q, s1_rot_q, s1_fneg_q;
  logic [3:0]  s1_neg_q, s1_neg_d;
  logic [7:0]  s1_ax_q, s1_ay_q, ax_d, ay_d, af_d;
  logic [15:0] s1_r2_q, s1_ossq_q, s1_p_q;
  logic [owdm_pkg::NumWheels-1:0][17:0] s1_to_q, s1_tb_q;

  // Stage 2
  logic        s2_v_q, s2_rot_q, s2_sat_q, sat_d;
  logic [3:0]  s2_neg_q;
  logic [15:0] s2_r2_q;
  logic [14:0] rm_d;
  logic [owdm_pkg::NumWheels-1:0][24:0] s2_ans_q, s2_as_q, s2_v_val_q;
  logic [owdm_pkg::NumWheels-1:0][7:0]  cmp_c;

  // Stage 3
  logic        s3_v_q;
  owdm_pkg::work_t s3_q;
  owdm_pkg::work_t s3_d;

  always_comb begin
    ax_d = stick_x_i[7] ? 8'(-stick_x_i) : 8'(stick_x_i);
    ay_d = stick_y_i[7] ? 8'(-stick_y_i) : 8'(stick_y_i);
    af_d = turn_percent_i[7] ? 8'(-turn_percent_i) : 8'(turn_percent_i);
    if (op_i) begin
      s1_neg_d = {turn_percent_i[7], 1'b0, turn_percent_i[7], 1'b0};
    end else begin
      s1_neg_d = {stick_x_i[7], stick_y_i[7],
                  !stick_x_i[7] && (stick_x_i != 8'sd0),
                  !stick_y_i[7] && (stick_y_i != 8'sd0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_rot_q  <= op_i;
      s1_fneg_q <= turn_percent_i[7];
      s1_neg_q  <= s1_neg_d;
      s1_ax_q   <= ax_d;
      s1_ay_q   <= ay_d;
      s1_r2_q   <= ({8'd0, ax_d} * {8'd0, ax_d}) + ({8'd0, ay_d} * {8'd0, ay_d});
      s1_ossq_q <= {8'd0, cfg_i.speed} * {8'd0, cfg_i.speed};
      s1_p_q    <= {8'd0, af_d} * {8'd0, cfg_i.speed};
      for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
        s1_to_q[w] <= 18'(cfg_i.trim[w]) * 18'(cfg_i.speed);
        s1_tb_q[w] <= 18'(cfg_i.trim[w]) * 18'd255;
      end
    end
  end

  // Wheels 0 and 2 follow y, wheels 1 and 3 follow x.
  always_comb begin
    for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
      cmp_c[w] = w[0] ? s1_ax_q : s1_ay_q;
    end
    sat_d = ({16'd0, s1_r2_q} * {16'd0, s1_ossq_q}) > owdm_pkg::XlateSatSq;
    if (!s1_fneg_q && (s1_p_q >= 16'(owdm_pkg::RotCap))) begin
      rm_d = owdm_pkg::RotCap;
    end else begin
      rm_d = s1_p_q[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_rot_q <= s1_rot_q;
      s2_neg_q <= s1_neg_q;
      s2_r2_q  <= s1_r2_q;
      s2_sat_q <= sat_d;
      for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
        s2_ans_q[w]   <= 25'(26'(s1_to_q[w]) * 26'(cmp_c[w]));
        s2_as_q[w]    <= 25'(26'(s1_tb_q[w]) * 26'(cmp_c[w]));
        s2_v_val_q[w] <= 25'(26'(cfg_i.trim[w]) * 26'(rm_d));
      end
    end
  end

  // Stage 3: square the scaled component; rotate magnitude is v / 25600 clamped on wheels 1 and 3, zero on 0 and 2.
  always_comb begin
    logic [24:0] a;
    logic [30:0] prod;
    s3_d      = '0;
    s3_d.rot  = s2_rot_q;
    s3_d.neg  = s2_neg_q;
    s3_d.den  = s2_sat_q ? {s2_r2_q, 16'd0} : owdm_pkg::XlateDivSq;
    for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
      a = s2_sat_q ? s2_as_q[w] : s2_ans_q[w];
      s3_d.num[w] = {25'd0, a} * {25'd0, a};
      prod = {16'd0, s2_v_val_q[w][22:8]} * {15'd0, owdm_pkg::RecipHundred};
      if (!w[0]) begin
        s3_d.pwm_rot[w] = 8'd0;
      end else if (s2_v_val_q[w] >= owdm_pkg::RotClampLim) begin
        s3_d.pwm_rot[w] = 8'd255;
      end else begin
        s3_d.pwm_rot[w] = prod[29:22];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv_i) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = s3_v_q;
  assign work_o  = s3_q;

endmodule

// ----- rtl/core/owdm_root.sv -----
// Eight-stage restoring search for min(floor(sqrt(num / den)), 255) on all four wheels,
// one result bit per stage. Depends on owdm_pkg.
module owdm_root (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  owdm_pkg::work_t work_i,
  output logic            valid_o,
  output owdm_pkg::work_t work_o
);

  logic            st_v [9];
  owdm_pkg::work_t st_w [9];

  assign st_v[0] = valid_i;
  assign st_w[0] = work_i;

  for (genvar k = 0; k < 8; k++) begin : g_step
    localparam int B = 7 - k;
    owdm_pkg::work_t nxt;
    logic            v_q;
    owdm_pkg::work_t w_q;

    // A trial root m|bit is kept when (m|bit)^2 * den <= num; the square is
    // built from the previous square so no second multiply is needed.
    always_comb begin
      logic [16:0] tsq;
      logic [47:0] prod;
      nxt = st_w[k];
      for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
        tsq  = 17'(st_w[k].sq[w]) + (17'(st_w[k].root[w]) << (B + 1)) + (17'd1 << (2 * B));
        prod = {32'd0, tsq[15:0]} * {16'd0, st_w[k].den};
        if ({2'b00, prod} <= st_w[k].num[w]) begin
          nxt.root[w] = st_w[k].root[w] | (8'd1 << B);
          nxt.sq[w]   = tsq[15:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv_i) begin
        v_q <= st_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        w_q <= nxt;
      end
    end

    assign st_v[k+1] = v_q;
    assign st_w[k+1] = w_q;
  end

  assign valid_o = st_v[8];
  assign work_o  = st_w[8];

endmodule

// ----- rtl/core/omni_wheel_drive_mixer.sv -----
// Top level of the four-wheel omni drive mixer: configuration registers, front end,
// root search and output register. Depends on owdm_pkg, owdm_front and owdm_root.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_stall_o   | op, stick_x, stick_y, turn_percent
//  output   | out_valid_o / out_stall_i | dir_* and pwm_* for the four wheels
//  config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle unless the output stalls; each passes to the output
// register through three front-end stages, eight root-search stages and the output stage.
// Reset clears the valid bits and loads speed 255 and unit trims.
// A stall on the output freezes the whole pipeline, so nothing is dropped or repeated.
module omni_wheel_drive_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owdm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owdm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [7:0]             stick_x_i,
  input  logic signed [7:0]             stick_y_i,
  input  logic signed [7:0]             turn_percent_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          dir_front_left_o,
  output logic [7:0]                    pwm_front_left_o,
  output logic                          dir_front_right_o,
  output logic [7:0]                    pwm_front_right_o,
  output logic                          dir_rear_left_o,
  output logic [7:0]                    pwm_rear_left_o,
  output logic                          dir_rear_right_o,
  output logic [7:0]                    pwm_rear_right_o
);

  owdm_pkg::cfg_t  cfg_q;
  logic            adv;
  logic            fe_valid, rt_valid;
  owdm_pkg::work_t fe_work, rt_work;
  logic            out_v_q;
  logic [owdm_pkg::NumWheels-1:0]      dir_d, dir_q;
  logic [owdm_pkg::NumWheels-1:0][7:0] pwm_d, pwm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed <= owdm_pkg::OsReset;
      for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
        cfg_q.trim[w] <= owdm_pkg::TrimReset;
      end
    end else if (cfg_we_i) begin
      unique case (owdm_pkg::cfg_reg_e'(cfg_idx_i))
        owdm_pkg::RegOpSpeed: cfg_q.speed   <= cfg_data_i[owdm_pkg::OsW-1:0];
        owdm_pkg::RegTrimFl:  cfg_q.trim[0] <= cfg_data_i;
        owdm_pkg::RegTrimFr:  cfg_q.trim[1] <= cfg_data_i;
        owdm_pkg::RegTrimRl:  cfg_q.trim[2] <= cfg_data_i;
        owdm_pkg::RegTrimRr:  cfg_q.trim[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  owdm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (in_valid_i),
    .op_i           (op_i),
    .stick_x_i      (stick_x_i),
    .stick_y_i      (stick_y_i),
    .turn_percent_i (turn_percent_i),
    .cfg_i          (cfg_q),
    .valid_o        (fe_valid),
    .work_o         (fe_work)
  );

  owdm_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fe_valid),
    .work_i  (fe_work),
    .valid_o (rt_valid),
    .work_o  (rt_work)
  );

  // A value that truncates to zero counts as non-negative.
  always_comb begin
    for (int w = 0; w < owdm_pkg::NumWheels; w++) begin
      pwm_d[w] = rt_work.rot ? rt_work.pwm_rot[w] : rt_work.root[w];
      dir_d[w] = !(rt_work.neg[w] && (pwm_d[w] != 8'd0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir_q <= dir_d;
      pwm_q <= pwm_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign dir_front_left_o  = dir_q[0];
  assign pwm_front_left_o  = pwm_q[0];
  assign dir_front_right_o = dir_q[1];
  assign pwm_front_right_o = pwm_q[1];
  assign dir_rear_left_o   = dir_q[2];
  assign pwm_rear_left_o   = pwm_q[2];
  assign dir_rear_right_o  = dir_q[3];
  assign pwm_rear_right_o  = pwm_q[3];

endmodule

// ----- rtl/core/owdm_checker.sv -----
// Port-level checker for the omni wheel drive mixer, bound to the top level.
// Depends on omni_wheel_drive_mixer_defines.svh.
`include "omni_wheel_drive_mixer_defines.svh"

module owdm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       dir_front_left_o,
  input logic [7:0] pwm_front_left_o,
  input logic       dir_rear_right_o,
  input logic [7:0] pwm_rear_right_o
);

  // The input side only stalls when a finished item is held at the output.
  `OWDM_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // A zero magnitude always reports the forward direction.
  `OWDM_ASSERT_IMPLY(a_zero_fwd_fl, out_valid_o && (pwm_front_left_o == 8'd0), dir_front_left_o, "front-left zero PWM with reverse direction")

  `OWDM_ASSERT_IMPLY(a_zero_fwd_rr, out_valid_o && (pwm_rear_right_o == 8'd0), dir_rear_right_o, "rear-right zero PWM with reverse direction")

  `OWDM_ASSERT_NEXT(a_hold_valid, out_valid_o && out_stall_i, out_valid_o && $stable(pwm_rear_right_o), "stalled output item changed")

endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (.*);
